// ----- src/sorted_alarm_queue_top_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted alarm queue assertion macros
// Concurrent check wrappers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_ALARM_QUEUE_TOP_DEFINES_SVH
`define SORTED_ALARM_QUEUE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SAQ_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication.
`define SAQ_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SAQ_ASSERT_IMP(lbl, pre, post, msg)
`define SAQ_ASSERT_NXT(lbl, pre, post, msg)
`endif

`endif

// ----- src/saq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted alarm queue package
// Shared sizes, codes and word types for the alarm queue cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package saq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ACT_W       = 8;
    localparam int TAG_W       = 16;
    localparam int TIME_W      = 32;
    localparam int RCNT_W      = 5;
    localparam int RCNT_MAX    = 31;
    localparam int CNT_RAW_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W       = (CNT_RAW_W > RCNT_W) ? CNT_RAW_W : RCNT_W;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_CANCEL = 2'd1,
        FUNC_GRAB   = 2'd2,
        FUNC_POP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_NONE = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_MARK,
        CELL_SQUEEZE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SQUEEZE,
        ST_DONE
    } state_t;

    typedef struct packed {
        func_t               func;
        logic [ACT_W-1:0]    action;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   alarm_time;
    } cmd_word_t;

    typedef struct packed {
        stat_t               status;
        logic [ACT_W-1:0]    out_action;
        logic [TAG_W-1:0]    out_tag;
        logic [TIME_W-1:0]   out_time;
        logic [RCNT_W-1:0]   removed_count;
    } rsp_word_t;

    typedef struct packed {
        logic                valid;
        logic                kill;
        logic [ACT_W-1:0]    action;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   due;
    } entry_t;

    typedef struct packed {
        cell_op_t            op;
        func_t               func;
        logic [ACT_W-1:0]    action;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   alarm_time;
    } cell_ctrl_t;

    typedef struct packed {
        logic                full;
        logic                any_kill;
        entry_t              pick;
    } chain_stat_t;

endpackage

`default_nettype wire

// ----- src/sorted_alarm_queue_top.sv -----
// ----------------------------------------------------------------------------
// Sorted alarm queue top level
// Command port, sequencer and response register around the slot chain.
// ----------------------------------------------------------------------------
// The queue holds up to 16 alarms sorted by due time in a row of slot cells,
// the head in slot 0. One command word is taken at a time: insert, cancel by
// mask, grab exact match, or pop due head. Insert shifts the later entries
// one slot back at once across the chain and places the new alarm after every
// entry due no later, so equal times leave first in, first out. Removals
// first mark the victims in every cell at once, then squeeze out one marked
// slot per cycle as the tail moves forward by one cell. An insert passes the
// execute and done states before the next command word is taken; a removal
// that drops k entries (k from 0 to 16) passes execute, k squeeze steps, a
// last check and done. The response word sits in an output register, so a
// command may be taken while an earlier response still waits under rsp_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_alarm_queue_top_defines.svh"

module sorted_alarm_queue_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire saq_pkg::cmd_word_t  cmd,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output saq_pkg::rsp_word_t       rsp
);

    localparam int CW = saq_pkg::CNT_W;

    saq_pkg::state_t      state_reg, state_next;
    saq_pkg::cmd_word_t   cmd_reg, cmd_next;
    saq_pkg::rsp_word_t   res_reg, res_next;
    saq_pkg::rsp_word_t   rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    saq_pkg::cell_ctrl_t  ctrl;
    saq_pkg::chain_stat_t chain_stat;
    logic [saq_pkg::RCNT_W-1:0] removed_sat;

    saq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (chain_stat)
    );

    // Take a new command only between operations.
    assign cmd_stall = (state_reg != saq_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Clamp the removal count to the width of the response field.
    assign removed_sat = (cnt_reg > CW'(saq_pkg::RCNT_MAX))
                         ? saq_pkg::RCNT_W'(saq_pkg::RCNT_MAX)
                         : cnt_reg[saq_pkg::RCNT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        ctrl.op         = saq_pkg::CELL_HOLD;
        ctrl.func       = cmd_reg.func;
        ctrl.action     = cmd_reg.action;
        ctrl.tag        = cmd_reg.tag;
        ctrl.alarm_time = cmd_reg.alarm_time;

        // Drop the response word once the far side takes it.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            saq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    cnt_next   = '0;
                    state_next = saq_pkg::ST_EXEC;
                end
            end

            saq_pkg::ST_EXEC:
            begin
                res_next = '0;
                if (cmd_reg.func == saq_pkg::FUNC_INSERT)
                begin
                    if (chain_stat.full)
                    begin
                        res_next.status = saq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        ctrl.op         = saq_pkg::CELL_INSERT;
                        res_next.status = saq_pkg::STAT_OK;
                    end
                    state_next = saq_pkg::ST_DONE;
                end
                else
                begin
                    // Mark victims; cancel reports done even with no hit.
                    ctrl.op         = saq_pkg::CELL_MARK;
                    res_next.status = (cmd_reg.func == saq_pkg::FUNC_CANCEL)
                                      ? saq_pkg::STAT_OK : saq_pkg::STAT_NONE;
                    state_next      = saq_pkg::ST_SQUEEZE;
                end
            end

            saq_pkg::ST_SQUEEZE:
            begin
                if (chain_stat.any_kill)
                begin
                    // Advance the tail over the first marked slot.
                    ctrl.op  = saq_pkg::CELL_SQUEEZE;
                    cnt_next = cnt_reg + CW'(1);
                    if (cmd_reg.func != saq_pkg::FUNC_CANCEL)
                    begin
                        res_next.status     = saq_pkg::STAT_OK;
                        res_next.out_action = chain_stat.pick.action;
                        res_next.out_tag    = chain_stat.pick.tag;
                        res_next.out_time   = chain_stat.pick.due;
                    end
                end
                else
                begin
                    state_next = saq_pkg::ST_DONE;
                end
            end

            saq_pkg::ST_DONE:
            begin
                // Hold until the response register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next               = res_reg;
                    rsp_next.removed_count = removed_sat;
                    rsp_valid_next         = 1'b1;
                    state_next             = saq_pkg::ST_IDLE;
                end
            end

            default:
                state_next = saq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= saq_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    // An accepted command word always starts execution next cycle.
    `SAQ_ASSERT_NXT(a_accept_exec, cmd_valid && !cmd_stall, state_reg == saq_pkg::ST_EXEC, "accepted word did not start execution")
    // No slot may stay marked once the sequencer is back to idle.
    `SAQ_ASSERT_IMP(a_idle_no_kill, state_reg == saq_pkg::ST_IDLE, !chain_stat.any_kill, "marked slot left after removal")
    // The squeeze count never passes the number of slots.
    `SAQ_ASSERT_IMP(a_cnt_bound, state_reg == saq_pkg::ST_SQUEEZE, cnt_reg <= CW'(saq_pkg::QUEUE_DEPTH), "removal count overran the queue")
    // An insert into a full chain must report full.
    `SAQ_ASSERT_NXT(a_full_flag, state_reg == saq_pkg::ST_EXEC && cmd_reg.func == saq_pkg::FUNC_INSERT && chain_stat.full, res_reg.status == saq_pkg::STAT_FULL, "full insert not flagged")

endmodule

`default_nettype wire

// ----- src/saq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted alarm queue cell
// One queue slot: compares against the command and trades with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module saq_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire saq_pkg::cell_ctrl_t ctrl,
    input  wire saq_pkg::entry_t     left,
    input  wire saq_pkg::entry_t     right,
    input  wire logic                left_keep,
    input  wire logic                left_kseen,
    input  wire logic                left_mseen,
    output saq_pkg::entry_t          cur,
    output logic                     keep,
    output logic                     kseen,
    output logic                     mseen,
    output logic                     first_kill
);

    saq_pkg::entry_t ent_reg;
    saq_pkg::entry_t ent_next;
    saq_pkg::entry_t fresh;
    logic            hit;
    logic            kill_mark;

    assign cur = ent_reg;

    // Entry stays put on insert when it is due no later than the new alarm.
    assign keep       = ent_reg.valid && (ctrl.alarm_time >= ent_reg.due);
    assign kseen      = left_kseen | ent_reg.kill;
    assign first_kill = ent_reg.kill & ~left_kseen;
    assign mseen      = left_mseen | hit;

    always_comb
    begin
        fresh.valid  = 1'b1;
        fresh.kill   = 1'b0;
        fresh.action = ctrl.action;
        fresh.tag    = ctrl.tag;
        fresh.due    = ctrl.alarm_time;

        case (ctrl.func)
            saq_pkg::FUNC_CANCEL:
                hit = ent_reg.valid && ((ent_reg.action & ctrl.action) != '0)
                      && ((ctrl.tag == '0) || (ent_reg.tag == ctrl.tag));
            saq_pkg::FUNC_GRAB:
                hit = ent_reg.valid && (ent_reg.action == ctrl.action)
                      && (ent_reg.tag == ctrl.tag);
            saq_pkg::FUNC_POP:
                hit = keep;
            default:
                hit = 1'b0;
        endcase

        // Cancel drops every hit; grab and pop drop only the first.
        kill_mark = (ctrl.func == saq_pkg::FUNC_CANCEL) ? hit : (hit & ~left_mseen);

        ent_next = ent_reg;
        case (ctrl.op)
            saq_pkg::CELL_INSERT:
            begin
                if (!keep)
                begin
                    ent_next = left_keep ? fresh : left;
                end
            end
            saq_pkg::CELL_MARK:
                ent_next.kill = kill_mark;
            saq_pkg::CELL_SQUEEZE:
            begin
                if (kseen)
                begin
                    ent_next = right;
                end
            end
            default:
                ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/saq_chain.sv -----
// ----------------------------------------------------------------------------
// Sorted alarm queue chain
// Row of slot cells, linked by neighbor data and prefix flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module saq_chain (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire saq_pkg::cell_ctrl_t ctrl,
    output saq_pkg::chain_stat_t     stat
);

    localparam int D = saq_pkg::QUEUE_DEPTH;

    saq_pkg::entry_t ent     [D];
    saq_pkg::entry_t left_e  [D];
    saq_pkg::entry_t right_e [D];
    logic            keep    [D];
    logic            kseen   [D];
    logic            mseen   [D];
    logic            fkill   [D];
    logic            lkeep   [D];
    logic            lkseen  [D];
    logic            lmseen  [D];
    saq_pkg::entry_t pick;

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_e[i] = '0;
            assign lkeep[i]  = 1'b1;
            assign lkseen[i] = 1'b0;
            assign lmseen[i] = 1'b0;
        end
        else
        begin : g_body
            assign left_e[i] = ent[i-1];
            assign lkeep[i]  = keep[i-1];
            assign lkseen[i] = kseen[i-1];
            assign lmseen[i] = mseen[i-1];
        end

        if (i == D - 1)
        begin : g_tail
            assign right_e[i] = '0;
        end
        else
        begin : g_inner
            assign right_e[i] = ent[i+1];
        end

        saq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left       (left_e[i]),
            .right      (right_e[i]),
            .left_keep  (lkeep[i]),
            .left_kseen (lkseen[i]),
            .left_mseen (lmseen[i]),
            .cur        (ent[i]),
            .keep       (keep[i]),
            .kseen      (kseen[i]),
            .mseen      (mseen[i]),
            .first_kill (fkill[i])
        );
    end

    // Select the first marked slot; at most one is flagged.
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < D; i++)
        begin
            pick = pick | (fkill[i] ? ent[i] : '0);
        end
    end

    assign stat.full     = ent[D-1].valid;
    assign stat.any_kill = kseen[D-1];
    assign stat.pick     = pick;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted alarm queue testbench
// Drives command words into the alarm queue and checks every response word
// against a queue model kept in the bench. A short table of directed words
// comes first, then three random phases with different idle and stall rates.
// ----------------------------------------------------------------------------

module tb;

    import saq_pkg::*;

    localparam int RANDOM_WORDS    = 500;   // per phase, three phases
    localparam int RSP_HOLD_CYCLES = 300;   // long response hold-off
    localparam int DRAIN_CYCLES    = 50;    // wait for stray words at the end
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no word moving
    localparam int DIRECTED_ROWS   = 27;

    localparam rsp_word_t RSP_DONE = '0;
    localparam rsp_word_t RSP_NONE = {STAT_NONE, 8'h00, 16'h0000, 32'h0, 5'd0};
    localparam rsp_word_t RSP_FULL = {STAT_FULL, 8'h00, 16'h0000, 32'h0, 5'd0};

    // One row of the directed table: the command word, and the response word
    // when it is obvious enough to type in; otherwise the model decides.
    typedef struct {
        cmd_word_t word;
        bit        known;
        rsp_word_t want;
    } step_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    cmd_word_t cmd       = '0;
    logic      rsp_stall = 1'b0;
    logic      cmd_stall;
    logic      rsp_valid;
    rsp_word_t rsp;

    // Alarm queue model: sorted by due time, head in slot 0.
    logic [TIME_W-1:0] q_due [QUEUE_DEPTH];
    logic [ACT_W-1:0]  q_act [QUEUE_DEPTH];
    logic [TAG_W-1:0]  q_tag [QUEUE_DEPTH];
    int                q_len = 0;

    rsp_word_t   replies_due[$];       // response words still to come, oldest first
    int          err_count      = 0;
    int          idle_cycles    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          rsp_hold_req   = 1'b0;
    logic [31:0] tick_now       = '0;  // moving "current time" for random words
    step_row_t   steps [DIRECTED_ROWS];

    sorted_alarm_queue_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------------

    // Drop one slot and close the gap behind it.
    function automatic void drop_slot(input int pos);
        int i;
        for (i = pos; i + 1 < q_len; i++)
        begin
            q_due[i] = q_due[i + 1];
            q_act[i] = q_act[i + 1];
            q_tag[i] = q_tag[i + 1];
        end
        q_len--;
    endfunction

    // Apply one command word to the model and return the response it earns.
    function automatic rsp_word_t run_alarm_cmd(input cmd_word_t w);
        rsp_word_t r;
        int        pos;
        int        i;
        int        hits;
        r    = RSP_DONE;
        hits = 0;
        case (w.func)
            FUNC_INSERT:
            begin
                if (q_len >= QUEUE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    // Go behind every entry due no later, so ties stay in order.
                    pos = 0;
                    while (pos < q_len && w.alarm_time >= q_due[pos])
                        pos++;
                    for (i = q_len; i > pos; i--)
                    begin
                        q_due[i] = q_due[i - 1];
                        q_act[i] = q_act[i - 1];
                        q_tag[i] = q_tag[i - 1];
                    end
                    q_due[pos] = w.alarm_time;
                    q_act[pos] = w.action;
                    q_tag[pos] = w.tag;
                    q_len++;
                end
            end
            FUNC_CANCEL:
            begin
                // Cancel always reports done, even when nothing matched.
                i = 0;
                while (i < q_len)
                begin
                    if ((q_act[i] & w.action) != '0 && (w.tag == '0 || q_tag[i] == w.tag))
                    begin
                        drop_slot(i);
                        hits++;
                    end
                    else
                        i++;
                end
                if (hits > RCNT_MAX)
                    hits = RCNT_MAX;
                r.removed_count = hits[RCNT_W-1:0];
            end
            FUNC_GRAB:
            begin
                r.status = STAT_NONE;
                for (i = 0; i < q_len; i++)
                begin
                    if (q_act[i] == w.action && q_tag[i] == w.tag)
                    begin
                        r = {STAT_OK, q_act[i], q_tag[i], q_due[i], 5'd1};
                        drop_slot(i);
                        break;
                    end
                end
            end
            default:
            begin
                // Pop: the head leaves only once it is due, compared unsigned.
                r.status = STAT_NONE;
                if (q_len > 0 && w.alarm_time >= q_due[0])
                begin
                    r = {STAT_OK, q_act[0], q_tag[0], q_due[0], 5'd1};
                    drop_slot(0);
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic cmd_word_t alarm_cmd(input func_t f, input logic [ACT_W-1:0] a,
                                            input logic [TAG_W-1:0] t,
                                            input logic [TIME_W-1:0] tm);
        cmd_word_t w;
        w.func       = f;
        w.action     = a;
        w.tag        = t;
        w.alarm_time = tm;
        return w;
    endfunction

    // Mostly a small pool of owners so that cancels and grabs find company.
    function automatic logic [TAG_W-1:0] pick_tag();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 65)
            return TAG_W'($urandom_range(6, 1));
        return TAG_W'($urandom_range(16'hffff));
    endfunction

    // Build one random command word, aimed at what the model currently holds.
    function automatic cmd_word_t pick_alarm_cmd();
        int                roll;
        int                r;
        int                slot;
        logic [ACT_W-1:0]  act;
        logic [TAG_W-1:0]  tg;
        logic [TIME_W-1:0] tm;
        func_t             f;
        tick_now = tick_now + $urandom_range(40);
        roll     = $urandom_range(99);
        r        = $urandom_range(99);
        slot     = (q_len > 0) ? $urandom_range(q_len - 1) : 0;
        act      = $urandom_range(1) ? (8'h01 << $urandom_range(7))
                                     : ACT_W'($urandom_range(8'hff));
        tg       = pick_tag();
        tm       = $urandom;
        if (roll < ((q_len < 12) ? 45 : 25))
        begin
            // Insert: mostly due soon, some ties with a held entry, some anywhere.
            f = FUNC_INSERT;
            if (r >= 20)
                tm = tick_now + $urandom_range(300);
            else if (r >= 10 && q_len > 0)
                tm = q_due[slot];
        end
        else if (roll < 70)
        begin
            f = FUNC_POP;
            if (r < 85)
                tm = tick_now;
            else if (r >= 95)
                tm = '1;
        end
        else if (roll < 85)
        begin
            // Grab: usually an exact copy of a held entry.
            f = FUNC_GRAB;
            if (q_len > 0 && r < 70)
            begin
                act = q_act[slot];
                tg  = q_tag[slot];
            end
        end
        else
        begin
            // Cancel: narrow masks mostly, an empty or full mask now and then.
            f = FUNC_CANCEL;
            if (r < 60)
                act = 8'h01 << $urandom_range(7);
            else if (r < 85)
                act = ACT_W'($urandom_range(8'hff));
            else if (r < 95)
                act = '0;
            else
                act = '1;
            r = $urandom_range(99);
            if (r < 50)
                tg = '0;
            else if (r < 75 && q_len > 0)
                tg = q_tag[slot];
        end
        return alarm_cmd(f, act, tg, tm);
    endfunction

    // Offer one word, idle at random first, and hold it until it is taken.
    task automatic send_word(input cmd_word_t w, input bit known, input rsp_word_t want);
        rsp_word_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        // Taken at this edge: advance the model and queue up the response.
        predicted = run_alarm_cmd(w);
        replies_due.push_back(known ? want : predicted);
    endtask

    // Drop valid and wait until every queued response has come back.
    task automatic drain_replies();
        cmd_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endfunction

    function automatic void check_reply(input rsp_word_t got);
        rsp_word_t want;
        if (replies_due.size() == 0)
        begin
            $error("response word with nothing outstanding: %h", got);
            err_count++;
        end
        else
        begin
            want = replies_due.pop_front();
            cmp_field("status",        32'(want.status),        32'(got.status));
            cmp_field("out_action",    32'(want.out_action),    32'(got.out_action));
            cmp_field("out_tag",       32'(want.out_tag),       32'(got.out_tag));
            cmp_field("out_time",      want.out_time,           got.out_time);
            cmp_field("removed_count", 32'(want.removed_count), 32'(got.removed_count));
        end
    endfunction

    // Response side: check each word taken, then pick the stall for the next
    // edge. A hold request from the command side stalls for a long stretch.
    initial
    begin : rsp_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                check_reply(rsp);
            if (rsp_hold_req)
            begin
                rsp_hold_req = 1'b0;
                hold_left    = RSP_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: count edges at which no word moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin : cmd_side
        int i;
        int phase;

        // Directed table: empty queue, sixteen inserts with extremes and ties,
        // insert into a full queue, pops due and not due, grabs (zero action
        // included), a tag-qualified cancel and a cancel that empties it all.
        steps = '{
            '{alarm_cmd(FUNC_POP,    8'hff, 16'hffff, 32'hffffffff), 1'b1, RSP_NONE},
            '{alarm_cmd(FUNC_GRAB,   8'h00, 16'h0000, 32'h00000000), 1'b1, RSP_NONE},
            '{alarm_cmd(FUNC_CANCEL, 8'hff, 16'h0000, 32'h00000000), 1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h00, 16'h0000, 32'h00000000), 1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'hff, 16'hffff, 32'hffffffff), 1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h01, 16'h0001, 32'd100),      1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h01, 16'h0002, 32'd100),      1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h02, 16'h0001, 32'd50),       1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h80, 16'h8000, 32'h7fffffff), 1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h00, 16'h1234, 32'd50),       1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h04, 16'h0003, 32'h80000000), 1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h01, 16'h0001, 32'd100),      1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h10, 16'h00ff, 32'd7),        1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h20, 16'h0002, 32'd200),      1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h40, 16'h0003, 32'd3),        1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h08, 16'h0001, 32'd1000),     1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h01, 16'h0004, 32'd1),        1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h02, 16'h0002, 32'd12),       1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h03, 16'haaaa, 32'd555),      1'b1, RSP_DONE},
            '{alarm_cmd(FUNC_INSERT, 8'h01, 16'h5555, 32'd9),        1'b1, RSP_FULL},
            '{alarm_cmd(FUNC_POP,    8'hff, 16'hffff, 32'd0),        1'b0, RSP_DONE},
            '{alarm_cmd(FUNC_POP,    8'h00, 16'h0000, 32'd0),        1'b0, RSP_DONE},
            '{alarm_cmd(FUNC_GRAB,   8'h00, 16'h1234, 32'd0),        1'b0, RSP_DONE},
            '{alarm_cmd(FUNC_GRAB,   8'h01, 16'h0002, 32'd0),        1'b0, RSP_DONE},
            '{alarm_cmd(FUNC_CANCEL, 8'h01, 16'h0001, 32'd0),        1'b0, RSP_DONE},
            '{alarm_cmd(FUNC_CANCEL, 8'hff, 16'h0000, 32'd0),        1'b0, RSP_DONE},
            '{alarm_cmd(FUNC_POP,    8'hff, 16'hffff, 32'hffffffff), 1'b1, RSP_NONE}
        };

        // Hold reset, then release it on a rising edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_word(steps[i].word, steps[i].known, steps[i].want);
        drain_replies();

        // Phase 0: light sender idling, heavy response stall.
        // Phase 1: the other way round.
        // Phase 2: no idling, but a long response hold-off up front so the
        // block fills and pushes back on the command side.
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 30 : (phase == 1) ? 85 : 0;
            recv_stall_pct = (phase == 0) ? 85 : (phase == 1) ? 30 : 0;
            if (phase == 2)
                rsp_hold_req = 1'b1;
            for (i = 0; i < RANDOM_WORDS; i++)
                send_word(pick_alarm_cmd(), 1'b0, RSP_DONE);
            drain_replies();
        end

        // Let any stray response word show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
